// ===== hdl/bis_pkg.sv =====
// Shared types and constants of the bucket insertion sorter.
package bis_pkg;

    localparam int VALUE_W          = 32;
    localparam int CFG_W            = 16;
    localparam int NUM_BUCKETS_DEF  = 10;
    localparam int CAPACITY_DEF     = 64;
    localparam int BUCKET_WIDTH_RST = 10;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_BKT,
        S_FETCH,
        S_CUR,
        S_SHIFT,
        S_PLACE,
        S_EMIT_RD,
        S_EMIT_WAIT
    } t_state;

    // one result as handed from the sequencer to the output register
    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      last_out;
        logic                      overflow;
    } t_out_item;

endpackage

// ===== hdl/bis_ifs.sv =====
// Valid/ready channel interfaces for the input items and the sorted results.
interface bis_in_if import bis_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      last_in;

    modport source (output valid, output value, output last_in, input ready);
    modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface bis_out_if import bis_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] sorted_value;
    logic                      last_out;
    logic                      overflow;

    modport source (output valid, output sorted_value, output last_out, output overflow,
                    input ready);
    modport sink   (input valid, input sorted_value, input last_out, input overflow,
                    output ready);
endinterface

// ===== hdl/bucket_insertion_sorter.sv =====
// Top level of the bucket insertion sorter.
//
// Input channel i_in_ch carries one signed 32-bit value per transfer and a
// last_in flag that closes the set. Each value is appended to its bucket in
// one memory: bucket j holds values from j times bucket_width upward, the top
// bucket takes the rest, negative values go to bucket 0. The block accepts
// an item, then writes it to the memory before it takes the next one.
// After the transfer marked last_in the block stops taking items, sorts each
// bucket by insertion sort in the memory and sends its values on o_out_ch in
// ascending order, bucket by bucket. Sorting is paced by the single read and
// single write port of the memory. The final result carries last_out;
// overflow is set on every result of a set in which values were dropped.
// A stalled receiver holds the output register and pauses the drain. The
// next set may start while the final result still waits in that register.
// Reset (synchronous, active low) empties all buckets and sets bucket_width
// to 10; no clearing pass is needed. i_cfg_we writes bucket_width; the user
// must write it only while idle, and the block itself does not enforce it.
module bucket_insertion_sorter import bis_pkg::*; #(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
    parameter int CAPACITY    = CAPACITY_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    bis_in_if.sink           i_in_ch,
    bis_out_if.source        o_out_ch
);
    localparam int BW = $clog2(NUM_BUCKETS);
    localparam int AW = BW + $clog2(CAPACITY);

    logic [BW-1:0]      w_bkt;
    logic               w_we, w_re;
    logic [AW-1:0]      w_waddr, w_raddr;
    logic [VALUE_W-1:0] w_wdata, w_rdata;
    logic               w_free, w_load;
    t_out_item          w_item;
    logic               r_out_valid;
    t_out_item          r_out;

    bis_bucket_sel #(.NUM_BUCKETS(NUM_BUCKETS)) u_sel (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_value    (i_in_ch.value),
        .o_bkt      (w_bkt)
    );

    bis_store #(.ADDR_W(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    bis_ctrl #(.NUM_BUCKETS(NUM_BUCKETS), .CAPACITY(CAPACITY)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .o_in_ready  (i_in_ch.ready),
        .i_value     (i_in_ch.value),
        .i_last      (i_in_ch.last_in),
        .i_bkt       (w_bkt),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_re        (w_re),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata),
        .i_out_free  (w_free),
        .o_item_load (w_load),
        .o_item      (w_item)
    );

    // output register: free when empty or being taken this cycle
    assign w_free = !r_out_valid || o_out_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_item;
        end
    end

    assign o_out_ch.valid        = r_out_valid;
    assign o_out_ch.sorted_value = r_out.sorted_value;
    assign o_out_ch.last_out     = r_out.last_out;
    assign o_out_ch.overflow     = r_out.overflow;

endmodule

// ===== hdl/bis_bucket_sel.sv =====
// Bucket bound registers and the bucket selection for an incoming value.
module bis_bucket_sel import bis_pkg::*; #(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [CFG_W-1:0]               i_cfg_data,
    input  logic [VALUE_W-1:0]             i_value,
    output logic [$clog2(NUM_BUCKETS)-1:0] o_bkt
);
    localparam int BW  = $clog2(NUM_BUCKETS);
    localparam int BDW = CFG_W + BW;

    logic [BDW-1:0]         r_bound [NUM_BUCKETS];
    logic [NUM_BUCKETS-1:0] w_ge;

    // hold the lower bound of every bucket, refreshed on a register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_BUCKETS; j++) begin
                r_bound[j] <= BDW'(j * BUCKET_WIDTH_RST);
            end
        end else if (i_cfg_we) begin
            for (int j = 0; j < NUM_BUCKETS; j++) begin
                r_bound[j] <= BDW'(i_cfg_data) * BDW'(j);
            end
        end
    end

    // compare against every bound; bounds rise with the index
    always_comb begin
        for (int j = 0; j < NUM_BUCKETS; j++) begin
            w_ge[j] = (i_value >= VALUE_W'(r_bound[j]));
        end
    end

    // pick the highest bound reached; negative values go to bucket 0
    always_comb begin
        o_bkt = '0;
        for (int j = 1; j < NUM_BUCKETS; j++) begin
            if (w_ge[j]) begin
                o_bkt = BW'(j);
            end
        end
        if (i_value[VALUE_W-1]) begin
            o_bkt = '0;
        end
    end

endmodule

// ===== hdl/bis_store.sv =====
// Bucket memory: one write port, one read port with registered read data.
module bis_store import bis_pkg::*; #(
    parameter int ADDR_W = 10
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [ADDR_W-1:0]  i_waddr,
    input  logic [VALUE_W-1:0] i_wdata,
    input  logic               i_re,
    input  logic [ADDR_W-1:0]  i_raddr,
    output logic [VALUE_W-1:0] o_rdata
);
    logic [VALUE_W-1:0] r_mem [2**ADDR_W];
    logic [VALUE_W-1:0] r_rdata;

    // write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/bis_ctrl.sv =====
// Sequencer: loads buckets, insertion-sorts each bucket in memory, drains results.
module bis_ctrl import bis_pkg::*; #(
    parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
    parameter int CAPACITY    = CAPACITY_DEF
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_in_valid,
    output logic                                             o_in_ready,
    input  logic [VALUE_W-1:0]                               i_value,
    input  logic                                             i_last,
    input  logic [$clog2(NUM_BUCKETS)-1:0]                   i_bkt,
    output logic                                             o_we,
    output logic [$clog2(NUM_BUCKETS)+$clog2(CAPACITY)-1:0]  o_waddr,
    output logic [VALUE_W-1:0]                               o_wdata,
    output logic                                             o_re,
    output logic [$clog2(NUM_BUCKETS)+$clog2(CAPACITY)-1:0]  o_raddr,
    input  logic [VALUE_W-1:0]                               i_rdata,
    input  logic                                             i_out_free,
    output logic                                             o_item_load,
    output t_out_item                                        o_item
);
    localparam int BW = $clog2(NUM_BUCKETS);
    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_state            r_state, n_state;
    logic [VALUE_W-1:0] r_val;
    logic              r_last;
    logic [BW-1:0]     r_ib;
    logic [CW-1:0]     r_fill [NUM_BUCKETS];
    logic [CW-1:0]     r_total;
    logic              r_drop;
    logic [BW-1:0]     r_bkt;
    logic [CW-1:0]     r_i;
    logic [SW-1:0]     r_j;
    logic [VALUE_W-1:0] r_cur;

    logic [CW-1:0]     w_n;
    logic              w_bkt_end;
    logic              w_lt;
    logic              w_room;

    assign w_n       = r_fill[r_bkt];
    assign w_bkt_end = (r_bkt == BW'(NUM_BUCKETS - 1));
    assign w_lt      = ($signed(r_cur) < $signed(i_rdata));
    assign w_room    = (r_total < CW'(CAPACITY));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_WRITE;
            S_WRITE:     n_state = r_last ? S_BKT : S_IDLE;
            S_BKT: begin
                if (w_n == '0) begin
                    n_state = w_bkt_end ? S_IDLE : S_BKT;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH:     n_state = (r_i >= w_n) ? S_EMIT_RD : S_CUR;
            S_CUR:       n_state = S_SHIFT;
            S_SHIFT: begin
                if (w_lt) begin
                    n_state = (r_j == SW'(1)) ? S_PLACE : S_SHIFT;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_PLACE:     n_state = S_FETCH;
            S_EMIT_RD: begin
                if (r_i == w_n) begin
                    n_state = w_bkt_end ? S_IDLE : S_BKT;
                end else begin
                    n_state = S_EMIT_WAIT;
                end
            end
            S_EMIT_WAIT: if (i_out_free) n_state = S_EMIT_RD;
            default:     n_state = S_IDLE;
        endcase
    end

    // memory accesses and handshake outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_we        = 1'b0;
        o_waddr     = {r_bkt, r_j};
        o_wdata     = r_cur;
        o_re        = 1'b0;
        o_raddr     = {r_bkt, r_i[SW-1:0]};
        o_item_load = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_WRITE: begin
                o_we    = w_room;
                o_waddr = {r_ib, r_fill[r_ib][SW-1:0]};
                o_wdata = r_val;
            end
            S_FETCH: o_re = (r_i < w_n);
            S_CUR: begin
                o_re    = 1'b1;
                o_raddr = {r_bkt, r_j - SW'(1)};
            end
            S_SHIFT: begin
                o_we    = 1'b1;
                o_wdata = w_lt ? i_rdata : r_cur;
                o_re    = w_lt && (r_j != SW'(1));
                o_raddr = {r_bkt, r_j - SW'(2)};
            end
            S_PLACE:     o_we = 1'b1;
            S_EMIT_RD:   o_re = (r_i != w_n);
            S_EMIT_WAIT: o_item_load = i_out_free;
            default: ;
        endcase
    end

    assign o_item.sorted_value = $signed(i_rdata);
    assign o_item.last_out     = (r_total == CW'(1));
    assign o_item.overflow     = r_drop;

    // state, counters and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_drop  <= 1'b0;
            r_bkt   <= '0;
            for (int b = 0; b < NUM_BUCKETS; b++) begin
                r_fill[b] <= '0;
            end
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_val  <= i_value;
                        r_last <= i_last;
                        r_ib   <= i_bkt;
                    end
                end
                // append to the bucket, or drop once the store is full
                S_WRITE: begin
                    if (w_room) begin
                        r_fill[r_ib] <= r_fill[r_ib] + CW'(1);
                        r_total      <= r_total + CW'(1);
                    end else begin
                        r_drop <= 1'b1;
                    end
                end
                S_BKT: begin
                    if (w_n == '0) begin
                        if (w_bkt_end) begin
                            r_bkt  <= '0;
                            r_drop <= 1'b0;
                            for (int b = 0; b < NUM_BUCKETS; b++) begin
                                r_fill[b] <= '0;
                            end
                        end else begin
                            r_bkt <= r_bkt + BW'(1);
                        end
                    end else begin
                        r_i <= CW'(1);
                    end
                end
                S_FETCH: begin
                    if (r_i >= w_n) begin
                        r_i <= '0;
                    end else begin
                        r_j <= r_i[SW-1:0];
                    end
                end
                S_CUR:   r_cur <= i_rdata;
                // shift the larger entry up, or place the current one
                S_SHIFT: begin
                    if (w_lt) begin
                        r_j <= r_j - SW'(1);
                    end else begin
                        r_i <= r_i + CW'(1);
                    end
                end
                S_PLACE: r_i <= r_i + CW'(1);
                S_EMIT_RD: begin
                    if (r_i == w_n) begin
                        if (w_bkt_end) begin
                            r_bkt  <= '0;
                            r_drop <= 1'b0;
                            for (int b = 0; b < NUM_BUCKETS; b++) begin
                                r_fill[b] <= '0;
                            end
                        end else begin
                            r_bkt <= r_bkt + BW'(1);
                        end
                    end
                end
                S_EMIT_WAIT: begin
                    if (i_out_free) begin
                        r_i     <= r_i + CW'(1);
                        r_total <= r_total - CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== hdl/bis_checker.sv =====
// Port-level checks of the bucket insertion sorter and their binding.
module bis_checker import bis_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [VALUE_W-1:0] i_out_value,
    input logic               i_out_last,
    input logic               i_out_ovf
);
    // a load transfer is followed by the memory write cycle
    a_write_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken in the cycle after a transfer");

    // no new set is taken while the drain of a set is unfinished
    a_drain_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_last) |-> !i_in_ready)
        else $error("input ready during drain");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_value) && $stable(i_out_last)
             && $stable(i_out_ovf)))
        else $error("stalled result changed");

endmodule

bind bucket_insertion_sorter bis_checker u_bis_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_ch.valid),
    .i_in_ready  (i_in_ch.ready),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_out_value (o_out_ch.sorted_value),
    .i_out_last  (o_out_ch.last_out),
    .i_out_ovf   (o_out_ch.overflow)
);
